/* hdl/assert_macros.svh */
// Assertion helpers for the hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sha2_pkg.sv */
package sha2_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [1:0] MODE_224 = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd1;
    localparam logic [1:0] MODE_384 = 2'd2;
    localparam logic [1:0] MODE_512 = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       start;
        logic       wide;
    } t_cmp_ctrl;

    function automatic logic [63:0] k512(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    // initial hash values per mode
    function automatic logic [63:0] init_value(input logic [1:0] mode, input logic [2:0] i);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        case (i)
            3'd0: begin a = 64'h6a09e667f3bcc908; b = 64'hcbbb9d5dc1059ed8; end
            3'd1: begin a = 64'hbb67ae8584caa73b; b = 64'h629a292a367cd507; end
            3'd2: begin a = 64'h3c6ef372fe94f82b; b = 64'h9159015a3070dd17; end
            3'd3: begin a = 64'ha54ff53a5f1d36f1; b = 64'h152fecd8f70e5939; end
            3'd4: begin a = 64'h510e527fade682d1; b = 64'h67332667ffc00b31; end
            3'd5: begin a = 64'h9b05688c2b3e6c1f; b = 64'h8eb44a8768581511; end
            3'd6: begin a = 64'h1f83d9abfb41bd6b; b = 64'hdb0c2e0d64f98fa7; end
            default: begin a = 64'h5be0cd19137e2179; b = 64'h47b5481dbefa4fa4; end
        endcase
        case (mode)
            MODE_224: v = {32'd0, b[31:0]};
            MODE_256: v = {32'd0, a[63:32]};
            MODE_384: v = b;
            default: v = a;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hdl/sha2_block_ram.sv */
// Byte-wide block store: one write port, one registered read port
module sha2_block_ram (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [6:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic [6:0] i_raddr,
    output logic [7:0] o_rdata
);
    logic [7:0] r_mem [0:127];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/sha2_round_core.sv */
// One SHA-2 round per cycle, the first 16 only on i_word_valid; schedule in a 16-entry window
module sha2_round_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha2_pkg::t_cmp_ctrl   i_ctrl,
    input  logic [63:0]           i_init [0:7],
    input  logic [63:0]           i_word,
    input  logic                  i_word_valid,
    output logic [63:0]           o_vars [0:7],
    output logic                  o_done
);
    logic [63:0] r_a [0:7];
    logic [63:0] r_w [0:15];
    logic [6:0]  r_t;
    logic        r_busy;
    logic        r_wide;
    logic [63:0] w_cur;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] bs0;
    logic [63:0] bs1;
    logic [63:0] ch;
    logic [63:0] mj;
    logic [63:0] t1;
    logic [63:0] kk;
    logic [6:0]  n_last;
    logic        step;

    assign n_last = r_wide ? 7'd79 : 7'd63;
    assign step   = r_busy && ((r_t >= 7'd16) || i_word_valid);

    // schedule word and round function
    always_comb begin
        kk = sha2_pkg::k512(r_t);
        if (r_wide) begin
            s0  = sha2_pkg::rotr64(r_w[1], 1) ^ sha2_pkg::rotr64(r_w[1], 8) ^ (r_w[1] >> 7);
            s1  = sha2_pkg::rotr64(r_w[14], 19) ^ sha2_pkg::rotr64(r_w[14], 61)
                ^ (r_w[14] >> 6);
            bs1 = sha2_pkg::rotr64(r_a[4], 14) ^ sha2_pkg::rotr64(r_a[4], 18)
                ^ sha2_pkg::rotr64(r_a[4], 41);
            bs0 = sha2_pkg::rotr64(r_a[0], 28) ^ sha2_pkg::rotr64(r_a[0], 34)
                ^ sha2_pkg::rotr64(r_a[0], 39);
        end else begin
            s0  = {32'd0, sha2_pkg::rotr32(r_w[1][31:0], 7) ^ sha2_pkg::rotr32(r_w[1][31:0], 18)
                ^ (r_w[1][31:0] >> 3)};
            s1  = {32'd0, sha2_pkg::rotr32(r_w[14][31:0], 17)
                ^ sha2_pkg::rotr32(r_w[14][31:0], 19) ^ (r_w[14][31:0] >> 10)};
            bs1 = {32'd0, sha2_pkg::rotr32(r_a[4][31:0], 6) ^ sha2_pkg::rotr32(r_a[4][31:0], 11)
                ^ sha2_pkg::rotr32(r_a[4][31:0], 25)};
            bs0 = {32'd0, sha2_pkg::rotr32(r_a[0][31:0], 2) ^ sha2_pkg::rotr32(r_a[0][31:0], 13)
                ^ sha2_pkg::rotr32(r_a[0][31:0], 22)};
            kk  = {32'd0, kk[63:32]};
        end
        w_cur = (r_t < 7'd16) ? i_word : (r_w[0] + s0 + r_w[9] + s1);
        if (!r_wide) begin
            w_cur = {32'd0, w_cur[31:0]};
        end
        ch = (r_a[4] & r_a[5]) ^ (~r_a[4] & r_a[6]);
        mj = (r_a[0] & r_a[1]) ^ (r_a[0] & r_a[2]) ^ (r_a[1] & r_a[2]);
        t1 = r_a[7] + bs1 + ch + kk + w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_t    <= '0;
            o_done <= 1'b0;
            r_wide <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
                r_wide <= i_ctrl.wide;
            end else if (step) begin
                r_t <= r_t + 7'd1;
                if (r_t == n_last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // working variables and window shift; w[0] is oldest
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            for (int i = 0; i < 8; i++) begin
                r_a[i] <= i_init[i];
            end
        end else if (step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
            r_a[7] <= r_a[6];
            r_a[6] <= r_a[5];
            r_a[5] <= r_a[4];
            r_a[4] <= r_wide ? r_a[3] + t1 : {32'd0, r_a[3][31:0] + t1[31:0]};
            r_a[3] <= r_a[2];
            r_a[2] <= r_a[1];
            r_a[1] <= r_a[0];
            r_a[0] <= r_wide ? t1 + bs0 + mj : {32'd0, t1[31:0] + bs0[31:0] + mj[31:0]};
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_vars[i] = r_a[i];
        end
    end
endmodule

/* hdl/sha2_stream_hasher.sv */
// Streaming SHA-2 hasher for SHA-224, SHA-256, SHA-384 and SHA-512, picked by the i_hash_mode
// register; a write drops any partial message. An input transaction carries at most one
// message byte. The transaction that fills a block stalls the input until that block is
// compressed and folded. The round unit takes schedule words one byte per cycle from the
// single read port of the block memory, so each of the first 16 rounds waits for the
// 4 (or 8) bytes of its word and the other 48 (or 64) run one per cycle. Load, read latency,
// word register, done flag and fold add to the stall. End of message then costs one padding
// write per byte left in the block and one compression. When the length field does not fit,
// a second padding pass of a full block and a second compression follow. Then come 7, 8, 12
// or 16 digest transactions, one per cycle while i_stall is low. No clearing pass after reset.
`include "assert_macros.svh"
module sha2_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hash_mode_we,
    input  logic [1:0]  i_hash_mode,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [3:0]  o_word_index,
    output logic        o_last_word
);
    sha2_pkg::t_state r_state, n_state;
    logic [1:0]  r_mode;
    logic [63:0] r_cv [0:7];
    logic [6:0]  r_fill, n_fill;
    logic [60:0] r_len, n_len;
    logic        r_end, n_end;
    logic [1:0]  r_pad, n_pad;
    logic [7:0]  r_ptr, n_ptr;
    logic [3:0]  r_bcnt, n_bcnt;
    logic [63:0] r_word, n_word;
    logic        r_wvalid, n_wvalid;
    logic        r_rdpend, n_rdpend;
    logic [4:0]  r_oidx, n_oidx;
    logic        r_ovalid, n_ovalid;
    logic        we;
    logic [6:0]  waddr;
    logic [7:0]  wdata;
    logic [6:0]  raddr;
    logic [7:0]  rdata;
    logic        wide;
    logic [7:0]  bs_last;
    logic [4:0]  nwords;
    logic [63:0] init [0:7];
    logic [63:0] vars [0:7];
    logic        cdone;
    logic        fold;
    sha2_pkg::t_cmp_ctrl ctrl;
    logic        acc;
    logic [63:0] bits;
    logic [63:0] cvsel;

    assign wide    = r_mode[1];
    assign bs_last = wide ? 8'd127 : 8'd63;
    assign bits    = {r_len, 3'b000};

    always_comb begin
        unique case (r_mode)
            sha2_pkg::MODE_224: nwords = 5'd7;
            sha2_pkg::MODE_256: nwords = 5'd8;
            sha2_pkg::MODE_384: nwords = 5'd12;
            default:            nwords = 5'd16;
        endcase
        for (int i = 0; i < 8; i++) begin
            init[i] = r_cv[i];
        end
    end

    sha2_block_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    sha2_round_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_init(init),
        .i_word(r_word), .i_word_valid(r_wvalid), .o_vars(vars), .o_done(cdone)
    );

    assign o_stall = (r_state != sha2_pkg::ST_IDLE);
    assign acc     = i_valid && !o_stall;

    // digest output selected from the chaining registers
    assign cvsel         = r_cv[wide ? r_oidx[3:1] : r_oidx[2:0]];
    assign o_valid       = r_ovalid;
    assign o_digest_word = (wide && !r_oidx[0]) ? cvsel[63:32] : cvsel[31:0];
    assign o_word_index  = r_oidx[3:0];
    assign o_last_word   = (r_oidx == nwords - 5'd1);

    // control sequencer
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_len    = r_len;
        n_end    = r_end;
        n_pad    = r_pad;
        n_ptr    = r_ptr;
        n_bcnt   = r_bcnt;
        n_word   = r_word;
        n_wvalid = 1'b0;
        n_rdpend = 1'b0;
        n_oidx   = r_oidx;
        n_ovalid = r_ovalid;
        we       = 1'b0;
        waddr    = r_fill;
        wdata    = i_data_byte;
        raddr    = r_ptr[6:0];
        ctrl     = '{start: 1'b0, wide: wide};
        fold     = 1'b0;
        unique case (r_state)
            sha2_pkg::ST_IDLE: begin
                if (acc) begin
                    n_end = i_end_of_message;
                    n_pad = 2'd0;
                    if (i_byte_present) begin
                        we     = 1'b1;
                        n_fill = r_fill + 7'd1;
                        n_len  = r_len + 61'd1;
                    end
                    if (i_byte_present && ({1'b0, r_fill} == bs_last)) begin
                        n_fill  = '0;
                        n_state = sha2_pkg::ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = sha2_pkg::ST_PAD;
                        n_pad   = 2'd0;
                    end
                end
            end
            sha2_pkg::ST_PAD: begin
                // pad 0 writes 0x80; then zeros, length in the last 8 bytes
                we = 1'b1;
                if (r_pad == 2'd0) begin
                    wdata  = sha2_pkg::PAD_BYTE;
                    n_pad  = 2'd1;
                end else begin
                    wdata = 8'd0;
                    if ({1'b0, r_fill} >= bs_last - 8'd7 && r_pad == 2'd2) begin
                        wdata = bits[8*(3'd7 - r_fill[2:0]) +: 8];
                    end
                end
                n_fill = r_fill + 7'd1;
                if ({1'b0, r_fill} == bs_last) begin
                    n_fill  = '0;
                    n_state = sha2_pkg::ST_LOAD;
                end
                if (r_pad == 2'd0) begin
                    // decide whether the length fits after the marker
                    n_pad = ({1'b0, r_fill} > bs_last - (wide ? 8'd16 : 8'd8)) ? 2'd1 : 2'd2;
                end
            end
            sha2_pkg::ST_LOAD: begin
                ctrl.start = 1'b1;
                n_ptr      = '0;
                n_bcnt     = '0;
                n_rdpend   = 1'b0;
                n_state    = sha2_pkg::ST_ROUND;
            end
            sha2_pkg::ST_ROUND: begin
                // one byte read per cycle until the block is fetched
                if (r_ptr <= bs_last) begin
                    n_ptr    = r_ptr + 8'd1;
                    n_rdpend = 1'b1;
                end
                // pack returned bytes into a schedule word for the first 16 rounds
                if (r_rdpend) begin
                    n_word = {r_word[55:0], rdata};
                    n_bcnt = r_bcnt + 4'd1;
                    if (r_bcnt == (wide ? 4'd7 : 4'd3)) begin
                        n_bcnt   = '0;
                        n_wvalid = 1'b1;
                        if (!wide) begin
                            n_word = {32'd0, r_word[23:0], rdata};
                        end
                    end
                end
                if (cdone) begin
                    n_state = sha2_pkg::ST_FOLD;
                end
            end
            sha2_pkg::ST_FOLD: begin
                fold = 1'b1;
                if (r_end) begin
                    if (r_pad == 2'd1) begin
                        n_pad   = 2'd2;
                        n_state = sha2_pkg::ST_PAD;
                    end else if (r_pad == 2'd2) begin
                        n_state  = sha2_pkg::ST_OUT;
                        n_oidx   = '0;
                        n_ovalid = 1'b1;
                    end else begin
                        n_state = sha2_pkg::ST_PAD;
                    end
                end else begin
                    n_state = sha2_pkg::ST_IDLE;
                end
            end
            sha2_pkg::ST_OUT: begin
                if (r_ovalid && !i_stall) begin
                    n_oidx = r_oidx + 5'd1;
                    if (o_last_word) begin
                        n_ovalid = 1'b0;
                        n_state  = sha2_pkg::ST_IDLE;
                        n_end    = 1'b0;
                        n_fill   = '0;
                        n_len    = '0;
                    end
                end
            end
            default: n_state = sha2_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha2_pkg::ST_IDLE;
            r_mode   <= sha2_pkg::MODE_256;
            r_fill   <= '0;
            r_len    <= '0;
            r_end    <= 1'b0;
            r_pad    <= '0;
            r_ptr    <= '0;
            r_bcnt   <= '0;
            r_wvalid <= 1'b0;
            r_rdpend <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= sha2_pkg::init_value(sha2_pkg::MODE_256, 3'(i));
            end
        end else if (i_hash_mode_we) begin
            r_mode <= i_hash_mode;
            r_fill <= '0;
            r_len  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= sha2_pkg::init_value(i_hash_mode, 3'(i));
            end
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_end    <= n_end;
            r_pad    <= n_pad;
            r_ptr    <= n_ptr;
            r_bcnt   <= n_bcnt;
            r_wvalid <= n_wvalid;
            r_rdpend <= n_rdpend;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
            if (fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_cv[i] <= wide ? r_cv[i] + vars[i]
                                    : {32'd0, r_cv[i][31:0] + vars[i][31:0]};
                end
            end else if (r_state == sha2_pkg::ST_OUT && n_state == sha2_pkg::ST_IDLE) begin
                for (int i = 0; i < 8; i++) begin
                    r_cv[i] <= sha2_pkg::init_value(r_mode, 3'(i));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // checks
    `SH_ASSERT_IMPL(a_no_out_idle, i_clk, i_rst_n, r_state == sha2_pkg::ST_IDLE, !o_valid)
    `SH_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, o_valid, r_oidx < nwords)
    `SH_ASSERT_NEXT(a_done_fold, i_clk, i_rst_n, cdone && !i_hash_mode_we, r_state == sha2_pkg::ST_FOLD)
endmodule
